// ----- sv/srl_pkg.sv -----
// ----------------------------------------------------------------------------
// srl_pkg: shared definitions for the smallest containing rectangle lookup
// Default sizes, opcodes, sequencer states and the sequencer control word.
// ----------------------------------------------------------------------------
package srl_pkg;

  localparam int MAX_ZONES_DEF  = 64;
  localparam int COORD_BITS_DEF = 20;

  // Width of the zone count register and of the reported zone index.
  localparam int CFG_W = 7;
  localparam int IDX_W = 6;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } seq_state_t;

  typedef struct packed {
    logic idle;
    logic issue;
    logic load_out;
  } seq_ctrl_t;

endpackage

// ----- sv/srl_store.sv -----
// ----------------------------------------------------------------------------
// srl_store: rectangle bounds memory
// Orders each written bound pair as min and max and keeps one row per entry.
// The read port is registered; one row is read per cycle.
// ----------------------------------------------------------------------------
module srl_store #(
  parameter int MAX_ZONES  = srl_pkg::MAX_ZONES_DEF,
  parameter int COORD_BITS = srl_pkg::COORD_BITS_DEF,
  parameter int AW         = 6
) (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [AW-1:0]                wr_addr,
  input  logic signed [COORD_BITS-1:0] wr_xa,
  input  logic signed [COORD_BITS-1:0] wr_xb,
  input  logic signed [COORD_BITS-1:0] wr_ya,
  input  logic signed [COORD_BITS-1:0] wr_yb,
  input  logic                         rd_en,
  input  logic [AW-1:0]                rd_addr,
  output logic signed [COORD_BITS-1:0] rd_x_min,
  output logic signed [COORD_BITS-1:0] rd_x_max,
  output logic signed [COORD_BITS-1:0] rd_y_min,
  output logic signed [COORD_BITS-1:0] rd_y_max
);

  localparam int C = COORD_BITS;

  logic [4*C-1:0] mem [MAX_ZONES];
  logic [4*C-1:0] rd_row_r;

  logic signed [C-1:0] x_lo, x_hi, y_lo, y_hi;

  always_comb begin
    x_lo = (wr_xa < wr_xb) ? wr_xa : wr_xb;
    x_hi = (wr_xa < wr_xb) ? wr_xb : wr_xa;
    y_lo = (wr_ya < wr_yb) ? wr_ya : wr_yb;
    y_hi = (wr_ya < wr_yb) ? wr_yb : wr_ya;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {x_lo, x_hi, y_lo, y_hi};
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_row_r <= mem[rd_addr];
    end
  end

  assign rd_x_min = $signed(rd_row_r[4*C-1:3*C]);
  assign rd_x_max = $signed(rd_row_r[3*C-1:2*C]);
  assign rd_y_min = $signed(rd_row_r[2*C-1:C]);
  assign rd_y_max = $signed(rd_row_r[C-1:0]);

endmodule

// ----- sv/srl_eval.sv -----
// ----------------------------------------------------------------------------
// srl_eval: containment and size evaluation unit
// Tests one stored rectangle per cycle against the query point, computes its
// width plus height, and keeps the smallest hit seen so far.
// ----------------------------------------------------------------------------
module srl_eval #(
  parameter int COORD_BITS = srl_pkg::COORD_BITS_DEF,
  parameter int AW         = 6
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic signed [COORD_BITS-1:0] qx,
  input  logic signed [COORD_BITS-1:0] qy,
  input  logic                         issue,
  input  logic [AW-1:0]                addr,
  input  logic signed [COORD_BITS-1:0] x_min,
  input  logic signed [COORD_BITS-1:0] x_max,
  input  logic signed [COORD_BITS-1:0] y_min,
  input  logic signed [COORD_BITS-1:0] y_max,
  output logic                         busy,
  output logic                         have,
  output logic [AW-1:0]                best_idx
);

  localparam int C = COORD_BITS;

  logic signed [C-1:0] qx_r, qy_r;

  // Stage one: memory read in flight, tagged with its entry index.
  logic          v1_r;
  logic [AW-1:0] idx1_r;

  // Stage two: containment flag and size of one entry.
  logic          v2_r;
  logic          hit2_r;
  logic [C:0]    size2_r;
  logic [AW-1:0] idx2_r;

  logic          have_r;
  logic [C:0]    best_size_r;
  logic [AW-1:0] best_idx_r;

  logic            hit_w;
  logic signed [C:0] dx_w, dy_w;
  logic [C:0]      size_w;

  always_comb begin
    hit_w = (x_min <= qx_r) && (qx_r <= x_max) && (y_min <= qy_r) && (qy_r <= y_max);
    dx_w  = (C+1)'(x_max) - (C+1)'(x_min);
    dy_w  = (C+1)'(y_max) - (C+1)'(y_min);
    // Both spans are never negative, so their low bits hold the full value.
    size_w = {1'b0, dx_w[C-1:0]} + {1'b0, dy_w[C-1:0]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      have_r <= 1'b0;
    end else begin
      v1_r <= issue;
      v2_r <= v1_r;
      if (start) begin
        have_r <= 1'b0;
      end else if (v2_r && hit2_r && (!have_r || size2_r < best_size_r)) begin
        have_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      qx_r <= qx;
      qy_r <= qy;
    end
    idx1_r  <= addr;
    hit2_r  <= hit_w;
    size2_r <= size_w;
    idx2_r  <= idx1_r;
    // Strict less-than keeps the lowest index on a tie.
    if (!start && v2_r && hit2_r && (!have_r || size2_r < best_size_r)) begin
      best_size_r <= size2_r;
      best_idx_r  <= idx2_r;
    end
  end

  assign busy     = v1_r | v2_r;
  assign have     = have_r;
  assign best_idx = best_idx_r;

endmodule

// ----- sv/srl_seq.sv -----
// ----------------------------------------------------------------------------
// srl_seq: query sequencer
// Steps the read address over the entries in use, waits for the evaluation
// pipeline to empty, then hands the result to the output register.
// ----------------------------------------------------------------------------
module srl_seq #(
  parameter int AW = 6,
  parameter int CW = 7
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [CW-1:0]       limit,
  input  logic                busy,
  input  logic                out_free,
  output srl_pkg::seq_ctrl_t  ctrl,
  output logic [AW-1:0]       addr
);

  srl_pkg::seq_state_t state_r, state_nxt;
  logic [AW-1:0]       addr_r, addr_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= srl_pkg::ST_IDLE;
      addr_r  <= '0;
    end else begin
      state_r <= state_nxt;
      addr_r  <= addr_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    addr_nxt      = addr_r;
    ctrl.idle     = 1'b0;
    ctrl.issue    = 1'b0;
    ctrl.load_out = 1'b0;
    case (state_r)
      srl_pkg::ST_IDLE: begin
        ctrl.idle = 1'b1;
        if (start) begin
          addr_nxt  = '0;
          state_nxt = (limit == '0) ? srl_pkg::ST_DRAIN : srl_pkg::ST_SCAN;
        end
      end
      srl_pkg::ST_SCAN: begin
        ctrl.issue = 1'b1;
        addr_nxt   = addr_r + AW'(1);
        if (CW'(addr_r) + CW'(1) == limit) begin
          state_nxt = srl_pkg::ST_DRAIN;
        end
      end
      srl_pkg::ST_DRAIN: begin
        if (!busy) begin
          state_nxt = srl_pkg::ST_FINISH;
        end
      end
      srl_pkg::ST_FINISH: begin
        if (out_free) begin
          ctrl.load_out = 1'b1;
          state_nxt     = srl_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = srl_pkg::ST_IDLE;
      end
    endcase
  end

  assign addr = addr_r;

endmodule

// ----- sv/smallest_containing_rect_lookup_unit.sv -----
// Write word: no result word; writes can follow back to back.
// Query word: scans N = min(zone_count, MAX_ZONES) entries (none when N is 0);
//   one entry is read per cycle, with two evaluation stages behind it.
// The next word is accepted only after the result is loaded, which waits while a result word stalls.
// Reset clears the sequencer, the output valid flag and zone_count (to 0);
//   the rectangle table is undefined until written.
// ----------------------------------------------------------------------------
// smallest_containing_rect_lookup_unit: smallest enclosing rectangle lookup
// Stores axis-aligned rectangles and reports, for a query point, the index
// of the containing rectangle with the least width plus height.
// ----------------------------------------------------------------------------
module smallest_containing_rect_lookup_unit #(
  parameter int MAX_ZONES  = srl_pkg::MAX_ZONES_DEF,
  parameter int COORD_BITS = srl_pkg::COORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [srl_pkg::CFG_W-1:0]     cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_op,
  input  logic [srl_pkg::IDX_W-1:0]     in_entry_index,
  input  logic signed [COORD_BITS-1:0]  in_bound_x_a,
  input  logic signed [COORD_BITS-1:0]  in_bound_x_b,
  input  logic signed [COORD_BITS-1:0]  in_bound_y_a,
  input  logic signed [COORD_BITS-1:0]  in_bound_y_b,
  input  logic signed [COORD_BITS-1:0]  in_query_x,
  input  logic signed [COORD_BITS-1:0]  in_query_y,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_found,
  output logic [srl_pkg::IDX_W-1:0]     out_zone_index
);

  localparam int AW    = (MAX_ZONES > 1) ? $clog2(MAX_ZONES) : 1;
  localparam int CLOG  = $clog2(MAX_ZONES + 1);
  localparam int CW    = (CLOG > srl_pkg::CFG_W) ? CLOG : srl_pkg::CFG_W;

  logic [srl_pkg::CFG_W-1:0] zone_count_r;
  logic                      out_valid_r;
  logic                      out_found_r;
  logic [srl_pkg::IDX_W-1:0] out_idx_r;

  srl_pkg::seq_ctrl_t ctrl;
  logic [AW-1:0]      scan_addr;
  logic [CW-1:0]      limit;
  logic               accept, wr_en, start, busy, have, out_free;
  logic [AW-1:0]      best_idx;
  logic signed [COORD_BITS-1:0] x_min, x_max, y_min, y_max;

  assign accept   = in_valid && !in_stall;
  assign in_stall = !ctrl.idle;
  assign start    = accept && (in_op == srl_pkg::OP_QUERY);
  // Writes aimed past the end of the table are dropped.
  assign wr_en    = accept && (in_op == srl_pkg::OP_WRITE)
                    && (int'(in_entry_index) < MAX_ZONES);
  assign limit    = (CW'(zone_count_r) > CW'(MAX_ZONES)) ? CW'(MAX_ZONES)
                                                         : CW'(zone_count_r);
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zone_count_r <= '0;
    end else if (cfg_wr_en) begin
      zone_count_r <= cfg_wr_data;
    end
  end

  srl_store #(
    .MAX_ZONES (MAX_ZONES),
    .COORD_BITS(COORD_BITS),
    .AW        (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (AW'(in_entry_index)),
    .wr_xa   (in_bound_x_a),
    .wr_xb   (in_bound_x_b),
    .wr_ya   (in_bound_y_a),
    .wr_yb   (in_bound_y_b),
    .rd_en   (ctrl.issue),
    .rd_addr (scan_addr),
    .rd_x_min(x_min),
    .rd_x_max(x_max),
    .rd_y_min(y_min),
    .rd_y_max(y_max)
  );

  srl_eval #(
    .COORD_BITS(COORD_BITS),
    .AW        (AW)
  ) u_eval (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .qx      (in_query_x),
    .qy      (in_query_y),
    .issue   (ctrl.issue),
    .addr    (scan_addr),
    .x_min   (x_min),
    .x_max   (x_max),
    .y_min   (y_min),
    .y_max   (y_max),
    .busy    (busy),
    .have    (have),
    .best_idx(best_idx)
  );

  srl_seq #(
    .AW(AW),
    .CW(CW)
  ) u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .limit   (limit),
    .busy    (busy),
    .out_free(out_free),
    .ctrl    (ctrl),
    .addr    (scan_addr)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_out) begin
      out_found_r <= have;
      out_idx_r   <= have ? srl_pkg::IDX_W'(best_idx) : '0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_found      = out_found_r;
  assign out_zone_index = out_idx_r;

endmodule

// ----- sv/srl_checker.sv -----
// ----------------------------------------------------------------------------
// srl_checker: port-level checks for the rectangle lookup
// Watches the handshakes and result words seen at the top level's ports.
// ----------------------------------------------------------------------------
module srl_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_stall,
  input logic                      in_op,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic                      out_found,
  input logic [srl_pkg::IDX_W-1:0] out_zone_index
);

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_found) && $stable(out_zone_index))
    else $error("stalled result word changed");

  // A miss always reports index zero.
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_zone_index == '0)
    else $error("miss reported a nonzero zone index");

  // A query keeps the input side stalled while the table is scanned.
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_op == srl_pkg::OP_QUERY |=> in_stall ##1 in_stall)
    else $error("input accepted during a query");

  // Reset leaves no result word pending.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word valid right after reset");

endmodule

bind smallest_containing_rect_lookup_unit srl_checker u_srl_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .in_op         (in_op),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_found     (out_found),
  .out_zone_index(out_zone_index)
);
